// ----- sv/ship_lite_srrip_replacement_unit_defines.svh -----
// Assertion macros used by the checker file of the replacement unit.
`ifndef SHIP_LITE_SRRIP_REPLACEMENT_UNIT_DEFINES_SVH
`define SHIP_LITE_SRRIP_REPLACEMENT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SHIP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ship assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SHIP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ship assertion failed");

`endif

// ----- sv/ship_pkg.sv -----
// Types and constants of the SHiP-lite SRRIP replacement unit.
package ship_pkg;

    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int SIG_ENTRIES = 2048;

    localparam int SET_IN_W = 11;
    localparam int WAY_W    = 4;
    localparam int PC_W     = 21;
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int SIG_W    = $clog2(SIG_ENTRIES);
    localparam int RRPV_W   = 2;
    localparam int CTR_W    = 2;
    localparam int ROW_W    = RRPV_W * NUM_WAYS;

    localparam int CLR_DEPTH = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int PADDR_W     = 3;

    localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_FAR  = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_START = 2'd2;
    localparam logic [CTR_W-1:0]  CTR_TOP   = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_FLOOR = 2'd0;
    localparam logic [CTR_W-1:0]  THR_RESET = 2'd2;

    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    // register word index (paddr[2])
    localparam logic REG_THRESHOLD = 1'b0;

    typedef struct packed {
        logic clear;    // write reset values at the sweep pointer
        logic capture;  // latch request, issue memory reads
        logic exec;     // compute and write back, load a query's result
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic is_query;
        logic out_blocked;
    } t_stat;

endpackage

// ----- sv/ship_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ship_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/ship_ctrl.sv -----
// Sequencer of the replacement unit: clear sweep, accept, execute.
module ship_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ship_pkg::t_stat i_stat,
    output ship_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // a query waits while the previous result is still held
                if (!(i_stat.is_query && i_stat.out_blocked)) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- sv/ship_dp.sv -----
// Datapath: RRPV and reuse-counter memories, signature hash, victim search.
module ship_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ship_pkg::t_cmd                  i_cmd,
    output ship_pkg::t_stat                 o_stat,
    input  logic [ship_pkg::CTR_W-1:0]      i_threshold,
    input  logic                            i_func,
    input  logic [ship_pkg::SET_IN_W-1:0]   i_set_index,
    input  logic [ship_pkg::WAY_W-1:0]      i_way,
    input  logic [ship_pkg::PC_W-1:0]       i_pc,
    input  logic                            i_hit,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ship_pkg::WAY_W-1:0]      o_victim_way
);

    localparam int SET_W  = ship_pkg::SET_W;
    localparam int SIG_W  = ship_pkg::SIG_W;
    localparam int WAY_W  = ship_pkg::WAY_W;
    localparam int ROW_W  = ship_pkg::ROW_W;
    localparam int CTR_W  = ship_pkg::CTR_W;
    localparam int RRPV_W = ship_pkg::RRPV_W;
    localparam int CLR_W  = ship_pkg::CLR_W;
    localparam int NWAYS  = ship_pkg::NUM_WAYS;

    // latched request
    logic             r_func;
    logic [SET_W-1:0] r_set;
    logic [WAY_W-1:0] r_way;
    logic [SIG_W-1:0] r_sig;
    logic             r_hit;

    logic [CLR_W-1:0] r_clr_cnt;
    logic             r_out_valid;
    logic [WAY_W-1:0] r_victim;

    logic [ship_pkg::PC_W-1:0] hash;
    logic [SIG_W-1:0]          sig_in;

    logic [ROW_W-1:0] row_rd;
    logic [CTR_W-1:0] ctr_rd;

    logic              top_hi;
    logic              top_lo;
    logic [RRPV_W-1:0] top;
    logic [RRPV_W-1:0] age_add;
    logic [ROW_W-1:0]  row_aged;
    logic [WAY_W-1:0]  victim;

    logic [CTR_W-1:0]  ctr_new;
    logic [RRPV_W-1:0] ins_rrpv;
    logic [ROW_W-1:0]  row_upd;
    logic              way_ok;

    logic             row_we;
    logic [SET_W-1:0] row_waddr;
    logic [ROW_W-1:0] row_wdata;
    logic             ctr_we;
    logic [SIG_W-1:0] ctr_waddr;
    logic [CTR_W-1:0] ctr_wdata;

    // signature: pc ^ pc>>4 ^ pc>>10, folded to the table size
    assign hash   = i_pc ^ (i_pc >> 4) ^ (i_pc >> 10);
    assign sig_in = hash[SIG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_set  <= i_set_index[SET_W-1:0];
            r_way  <= i_way;
            r_sig  <= sig_in;
            r_hit  <= i_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // set maximum, aging and lowest way at the maximum
    always_comb begin
        top_hi = 1'b0;
        top_lo = 1'b0;
        for (int w = 0; w < NWAYS; w++) begin
            top_hi = top_hi | row_rd[RRPV_W*w+1];
        end
        for (int w = 0; w < NWAYS; w++) begin
            top_lo = top_lo | (row_rd[RRPV_W*w] & (row_rd[RRPV_W*w+1] == top_hi));
        end
        top     = {top_hi, top_lo};
        age_add = ship_pkg::RRPV_FAR - top;
        victim  = '0;
        for (int w = NWAYS - 1; w >= 0; w--) begin
            row_aged[RRPV_W*w +: RRPV_W] = row_rd[RRPV_W*w +: RRPV_W] + age_add;
            if (row_rd[RRPV_W*w +: RRPV_W] == top) begin
                victim = WAY_W'(w);
            end
        end
    end

    // hit promotes, inserts near; miss demotes, inserts by the new counter
    always_comb begin
        if (r_hit) begin
            ctr_new  = (ctr_rd == ship_pkg::CTR_TOP) ? ctr_rd : ctr_rd + 1'b1;
            ins_rrpv = ship_pkg::RRPV_NEAR;
        end else begin
            ctr_new  = (ctr_rd == ship_pkg::CTR_FLOOR) ? ctr_rd : ctr_rd - 1'b1;
            ins_rrpv = (ctr_new >= i_threshold) ? ship_pkg::RRPV_NEAR : ship_pkg::RRPV_FAR;
        end
        row_upd = row_rd;
        row_upd[{r_way, 1'b0} +: RRPV_W] = ins_rrpv;
        way_ok = {1'b0, r_way} < (WAY_W + 1)'(NWAYS);
    end

    always_comb begin
        if (i_cmd.clear) begin
            row_we    = {1'b0, r_clr_cnt} < (CLR_W + 1)'(ship_pkg::NUM_SETS);
            row_waddr = r_clr_cnt[SET_W-1:0];
            row_wdata = {ship_pkg::NUM_WAYS{ship_pkg::RRPV_FAR}};
            ctr_we    = {1'b0, r_clr_cnt} < (CLR_W + 1)'(ship_pkg::SIG_ENTRIES);
            ctr_waddr = r_clr_cnt[SIG_W-1:0];
            ctr_wdata = ship_pkg::CTR_START;
        end else begin
            row_we    = i_cmd.exec && ((r_func == ship_pkg::FUNC_QUERY) || way_ok);
            row_waddr = r_set;
            row_wdata = (r_func == ship_pkg::FUNC_QUERY) ? row_aged : row_upd;
            ctr_we    = i_cmd.exec && (r_func == ship_pkg::FUNC_UPDATE);
            ctr_waddr = r_sig;
            ctr_wdata = ctr_new;
        end
    end

    ship_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ship_pkg::NUM_SETS)
    ) u_rrpv_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (i_set_index[SET_W-1:0]),
        .o_rdata (row_rd)
    );

    ship_ram #(
        .WIDTH (CTR_W),
        .DEPTH (ship_pkg::SIG_ENTRIES)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ctr_we),
        .i_waddr (ctr_waddr),
        .i_wdata (ctr_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (sig_in),
        .o_rdata (ctr_rd)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec && (r_func == ship_pkg::FUNC_QUERY)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && (r_func == ship_pkg::FUNC_QUERY)) begin
            r_victim <= victim;
        end
    end

    assign o_stat.clear_last  = r_clr_cnt == CLR_W'(ship_pkg::CLR_DEPTH - 1);
    assign o_stat.is_query    = r_func == ship_pkg::FUNC_QUERY;
    assign o_stat.out_blocked = r_out_valid && !i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_victim_way = r_victim;

endmodule

// ----- sv/ship_lite_srrip_replacement_unit.sv -----
// Top level of the SHiP-lite SRRIP cache replacement unit.
//
// Requests arrive on the s_axis channel. s_axis_tuser = 0 is a victim
// query for a set: the set is aged so its largest RRPV becomes 3 and
// the lowest way at 3 comes back on m_axis. s_axis_tuser = 1 is a hit
// or fill update; it writes one way's RRPV and the reuse counter picked
// by the PC signature, and returns nothing.
// In the accept cycle the set row and the counter are read from their
// RAMs; in the execute cycle the row is written back, an update also
// writes the counter, and a query loads the result register. One
// request is in flight at a time; the RAMs are read, then written.
// A query result appears on m_axis in the cycle after its execute cycle.
// While m_axis stalls, updates go on; a further query holds in its
// execute cycle until the result register is taken.
// After reset a clear sweep writes every RRPV to 3 and every counter
// to 2, one entry a cycle over 2048 entries; s_axis_tready stays low
// until it ends. The APB port holds reuse_threshold (reset 2) at
// byte address 0 and may be written at any time while no request is
// in flight.
module ship_lite_srrip_replacement_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ship_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: set_index[10:0], way[14:11], pc[35:15], hit[36], zero pad
    input  logic [ship_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: func[0]
    input  logic                              s_axis_tuser,
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: victim_way[3:0], zero pad
    output logic [ship_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int WAY_W = ship_pkg::WAY_W;

    logic [ship_pkg::CTR_W-1:0] r_threshold;
    logic                       cfg_wr;

    ship_pkg::t_cmd  cmd;
    ship_pkg::t_stat stat;

    logic [WAY_W-1:0] victim_way;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == ship_pkg::REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ship_pkg::THR_RESET;
        end else if (cfg_wr) begin
            r_threshold <= pwdata[ship_pkg::CTR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ship_pkg::REG_THRESHOLD)
                    ? {{(32 - ship_pkg::CTR_W){1'b0}}, r_threshold} : 32'd0;

    ship_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ship_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_threshold  (r_threshold),
        .i_func       (s_axis_tuser),
        .i_set_index  (s_axis_tdata[10:0]),
        .i_way        (s_axis_tdata[14:11]),
        .i_pc         (s_axis_tdata[35:15]),
        .i_hit        (s_axis_tdata[36]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_victim_way (victim_way)
    );

    assign m_axis_tdata = {{(ship_pkg::OUT_TDATA_W - WAY_W){1'b0}}, victim_way};

endmodule

// ----- sv/ship_chk.sv -----
// Port-level checker of the replacement unit, bound to the top level.
`include "ship_lite_srrip_replacement_unit_defines.svh"

module ship_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ship_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // one request in flight: never accepted in consecutive cycles
    `SHIP_ASSERT_NXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a fresh result traces back to an accepted query
    `SHIP_ASSERT_IMP(a_result_from_query, $rose(m_axis_tvalid),
        $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == ship_pkg::FUNC_QUERY), 2))

    // a stalled result holds
    `SHIP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind ship_lite_srrip_replacement_unit ship_chk u_ship_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/ship_lite_srrip_replacement_unit_test.sv -----
// Self-checking testbench for the SHiP-lite SRRIP replacement unit.
module ship_lite_srrip_replacement_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ship_pkg::*;

    // One request as it travels on s_axis (func rides in tuser).
    typedef struct packed {
        logic                func;
        logic [SET_IN_W-1:0] set_idx;
        logic [WAY_W-1:0]    way;
        logic [PC_W-1:0]     pc;
        logic                hit;
    } t_ship_req;

    localparam int WATCHDOG_LIMIT = 10000; // outlasts the clear sweep
    localparam int SETTLE_CYCLES  = 8;     // an update may still be writing back
    localparam int PHASE_ITEMS    = 420;
    localparam int HOT_SETS       = 8;
    localparam int HOT_PCS        = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    ship_lite_srrip_replacement_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata: set_index[10:0], way[14:11], pc[35:15], hit[36], zero pad
        .s_axis_tdata  (s_axis_tdata),
        // tuser: func[0]
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata: victim_way[3:0], zero pad
        .m_axis_tdata  (m_axis_tdata)
    );

    // Mirror of the replacement state, kept in request order.
    logic [RRPV_W-1:0] rrpv_mirror [NUM_SETS][NUM_WAYS];
    logic [CTR_W-1:0]  reuse_mirror [SIG_ENTRIES];
    logic [CTR_W-1:0]  thr_mirror;

    t_ship_req         pending_reqs[$];   // requests waiting for the driver
    logic [WAY_W-1:0]  victim_queue[$];   // victims owed on m_axis

    int  err_cnt;
    int  idle_cycles;
    bit  no_idle;       // last phase runs both sides flat out
    int  gap_odds;      // 1-in-N chance of a source gap burst
    int  stall_odds;    // 1-in-N chance of a sink stall burst
    int  src_gap, src_quiet, snk_stall, snk_quiet;
    bit  s_took;        // request accepted at the last rising edge

    logic [SET_IN_W-1:0] hot_set [HOT_SETS];
    logic [PC_W-1:0]     hot_pc  [HOT_PCS];

    // accept-time bookkeeping
    t_ship_req        acc_req;
    bit               acc_gives;
    logic [WAY_W-1:0] acc_victim;
    logic [WAY_W-1:0] want_victim;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Signature: PC folded with itself at shifts 4 and 10, low bits kept.
    function automatic logic [SIG_W-1:0] sig_hash(input logic [PC_W-1:0] pc);
        logic [PC_W-1:0] folded;
        folded = pc ^ (pc >> 4) ^ (pc >> 10);
        return folded[SIG_W-1:0];
    endfunction

    // Advance the mirror by one request; a query hands back its victim.
    task automatic model_request(input t_ship_req r, output bit gives,
                                 output logic [WAY_W-1:0] victim);
        logic [SET_W-1:0]  s;
        logic [SIG_W-1:0]  sig;
        logic [RRPV_W-1:0] top;
        logic [RRPV_W-1:0] lift;
        logic [CTR_W-1:0]  c;
        bit                found;
        s      = r.set_idx[SET_W-1:0];
        gives  = 1'b0;
        victim = '0;
        if (r.func == FUNC_QUERY) begin
            // aging closes the gap between the set's max RRPV and far
            top = '0;
            for (int w = 0; w < NUM_WAYS; w++)
                if (rrpv_mirror[s][w] > top) top = rrpv_mirror[s][w];
            lift  = RRPV_FAR - top;
            found = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                rrpv_mirror[s][w] = rrpv_mirror[s][w] + lift;
                if (!found && rrpv_mirror[s][w] == RRPV_FAR) begin
                    victim = WAY_W'(w);
                    found  = 1'b1;
                end
            end
            gives = 1'b1;
        end else begin
            sig = sig_hash(r.pc);
            c   = reuse_mirror[sig];
            if (r.hit) begin
                if (c != CTR_TOP) c = c + 1'b1;
                reuse_mirror[sig]    = c;
                rrpv_mirror[s][r.way] = RRPV_NEAR;
            end else begin
                if (c != CTR_FLOOR) c = c - 1'b1;
                reuse_mirror[sig]    = c;
                rrpv_mirror[s][r.way] = (c >= thr_mirror) ? RRPV_NEAR : RRPV_FAR;
            end
        end
    endtask

    task automatic push_req(input logic func, input logic [SET_IN_W-1:0] set_idx,
                            input logic [WAY_W-1:0] way, input logic [PC_W-1:0] pc,
                            input logic hit);
        t_ship_req r;
        r.func    = func;
        r.set_idx = set_idx;
        r.way     = way;
        r.pc      = pc;
        r.hit     = hit;
        pending_reqs.push_back(r);
    endtask

    // Mostly hot sets and hot PCs so queries see aged rows and counters
    // saturate; the rest spans the full field ranges.
    task automatic push_random_req();
        logic                func;
        logic [SET_IN_W-1:0] set_idx;
        logic [PC_W-1:0]     pc;
        func    = ($urandom_range(0, 99) < 35) ? FUNC_QUERY : FUNC_UPDATE;
        set_idx = ($urandom_range(0, 99) < 85) ? hot_set[$urandom_range(0, HOT_SETS-1)]
                                               : SET_IN_W'($urandom);
        pc      = ($urandom_range(0, 99) < 70) ? hot_pc[$urandom_range(0, HOT_PCS-1)]
                                               : PC_W'($urandom);
        push_req(func, set_idx, WAY_W'($urandom), pc, 1'($urandom));
    endtask

    // Wait until the block has nothing left to do, then let it settle.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || s_axis_tvalid || victim_queue.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data,
                              output logic [31:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {REG_THRESHOLD, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the threshold, then read it back.
    task automatic set_threshold(input logic [CTR_W-1:0] thr);
        logic [31:0] rd;
        apb_access(1'b1, 32'(thr), rd);
        thr_mirror = thr;
        apb_access(1'b0, '0, rd);
        if (rd !== 32'(thr)) begin
            $display("%0t: threshold readback expected %0h actual %0h", $realtime, thr, rd);
            err_cnt++;
        end
    endtask

    // Request driver: a held request stays put until it is accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (src_quiet > 0) src_quiet--;
            else if ($urandom_range(0, 49) == 0) src_quiet = $urandom_range(30, 120);
            if (!s_axis_tvalid || s_took) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (!no_idle && src_quiet == 0 &&
                             $urandom_range(0, gap_odds - 1) == 0) begin
                    src_gap = $urandom_range(1, 15) - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    acc_req = pending_reqs.pop_front();
                    s_axis_tdata  <= {3'b000, acc_req.hit, acc_req.pc, acc_req.way,
                                      acc_req.set_idx};
                    s_axis_tuser  <= acc_req.func;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Result sink: back-pressure in bursts, quiet stretches in between.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (snk_quiet > 0) snk_quiet--;
            else if ($urandom_range(0, 49) == 0) snk_quiet = $urandom_range(30, 120);
            if (snk_stall > 0) begin
                snk_stall--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && snk_quiet == 0 &&
                         $urandom_range(0, stall_odds - 1) == 0) begin
                snk_stall = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: predict on every accepted request, check every result.
    always @(posedge i_clk) begin
        s_took <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            model_request({s_axis_tuser, s_axis_tdata[10:0], s_axis_tdata[14:11],
                           s_axis_tdata[35:15], s_axis_tdata[36]}, acc_gives, acc_victim);
            if (acc_gives) victim_queue.push_back(acc_victim);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (victim_queue.size() == 0) begin
                $display("%0t: victim_way expected none actual %0d", $realtime,
                         m_axis_tdata[3:0]);
                err_cnt++;
            end else begin
                want_victim = victim_queue.pop_front();
                if (m_axis_tdata[3:0] !== want_victim) begin
                    $display("%0t: victim_way expected %0d actual %0d", $realtime,
                             want_victim, m_axis_tdata[3:0]);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either stream.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d requests queued, %0d victims owed",
                     $realtime, pending_reqs.size(), victim_queue.size());
            $display("** ship_lite_srrip_replacement_unit: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_QUERY;
        m_axis_tready = 1'b0;
        s_took        = 1'b0;
        err_cnt       = 0;
        idle_cycles   = 0;
        no_idle       = 1'b0;
        gap_odds      = 4;
        stall_odds    = 4;
        src_gap       = 0;
        src_quiet     = 0;
        snk_stall     = 0;
        snk_quiet     = 0;
        thr_mirror    = THR_RESET;
        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++) rrpv_mirror[s][w] = RRPV_FAR;
        for (int i = 0; i < SIG_ENTRIES; i++) reuse_mirror[i] = CTR_START;
        for (int i = 0; i < HOT_SETS; i++) hot_set[i] = SET_IN_W'($urandom);
        for (int i = 0; i < HOT_PCS; i++) hot_pc[i] = PC_W'($urandom);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: fresh set, hit saturation, a row pulled fully near
        // and then aged back to far, miss counter floor.
        push_req(FUNC_QUERY, '0, '0, '0, 1'b0);
        for (int w = 0; w < NUM_WAYS - 1; w++)
            push_req(FUNC_UPDATE, '1, WAY_W'(w), '0, 1'b1);
        push_req(FUNC_UPDATE, '1, '1, '0, 1'b0);       // counter 3 -> 2, inserted near
        push_req(FUNC_QUERY, '1, '0, '1, 1'b1);        // every way ages 0 -> 3
        for (int i = 0; i < 3; i++)
            push_req(FUNC_UPDATE, '0, WAY_W'(i * 7), '1, 1'b0);  // 2 -> 1 -> 0 -> 0
        push_req(FUNC_QUERY, '0, '0, '0, 1'b0);

        // Random phases, one per threshold setting; the last one without idling.
        for (int i = 0; i < PHASE_ITEMS; i++) push_random_req();
        wait_drained();

        set_threshold(2'd0);
        gap_odds   = 2;
        stall_odds = 8;
        for (int i = 0; i < PHASE_ITEMS; i++) push_random_req();
        wait_drained();

        set_threshold(2'd3);
        gap_odds   = 8;
        stall_odds = 2;
        for (int i = 0; i < PHASE_ITEMS; i++) push_random_req();
        wait_drained();

        set_threshold(2'd1);
        no_idle = 1'b1;
        for (int i = 0; i < PHASE_ITEMS; i++) push_random_req();
        wait_drained();

        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("** ship_lite_srrip_replacement_unit: PASSED **");
        end else begin
            $display("** ship_lite_srrip_replacement_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- ship_lite_srrip_replacement_unit.f -----
+incdir+sv
sv/ship_pkg.sv
sv/ship_ram.sv
sv/ship_ctrl.sv
sv/ship_dp.sv
sv/ship_lite_srrip_replacement_unit.sv
sv/ship_chk.sv
test/ship_lite_srrip_replacement_unit_test.sv
